>>> hw/rtl/lfsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared constants for the line filter / fixed-pattern match unit.
// ----------------------------------------------------------------------------
package lfsm_pkg;

   // input item kinds
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // result item kinds
   localparam logic OUT_ECHO    = 1'b0;
   localparam logic OUT_VERDICT = 1'b1;

   // stream byte codes
   localparam logic [7:0] BYTE_SKIP_SHORT = 8'hFF;
   localparam logic [7:0] BYTE_SKIP_LONG  = 8'hFE;
   localparam logic [7:0] BYTE_CR         = 8'd13;
   localparam logic [7:0] BYTE_LF         = 8'd10;
   localparam logic [7:0] BYTE_TAB        = 8'd9;
   localparam logic [7:0] PRINT_LOW       = 8'd32;
   localparam logic [7:0] PRINT_HIGH      = 8'd126;

   localparam logic [4:0] SKIP_SHORT = 5'd3;
   localparam logic [4:0] SKIP_LONG  = 5'd16;

   localparam int NEEDLE_BYTES   = 16;
   localparam int LEN_OUT_WIDTH  = 9;

   // register indexes on the csr channel
   localparam logic [1:0] REG_NEEDLE_LOW  = 2'd0;
   localparam logic [1:0] REG_NEEDLE_HIGH = 2'd1;
   localparam logic [1:0] REG_NEEDLE_LEN  = 2'd2;

   typedef logic [7:0] char_type;

endpackage

>>> hw/rtl/lfsm_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsm_match
// Parallel compare of the incoming byte plus the stored history against the
// tail-aligned needle.
// ----------------------------------------------------------------------------
module lfsm_match
   import lfsm_pkg::*;
#(
   parameter int NEEDLE_MAX = 16,
   parameter int HIST_DEPTH = 15
) (
   input  char_type                      char_value,
   input  char_type                      history [HIST_DEPTH],
   input  logic [8*NEEDLE_BYTES-1:0]     needle,
   input  logic [4:0]                    pattern_size,
   output logic                          hit
);

   char_type   window [NEEDLE_MAX];
   logic [3:0] pos    [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0] pos_ok;

   // window[0] is the new byte, window[i] the byte i steps back; it must
   // equal needle byte len-1-i for every i below the needle length
   always_comb begin
      for (int i = 0; i < NEEDLE_MAX; i++) begin
         window[i] = (i == 0) ? char_value : history[(i > 0) ? i - 1 : 0];
         pos[i]    = 4'(pattern_size - 5'd1 - 5'(i));
         pos_ok[i] = (5'(i) >= pattern_size) ||
                     (window[i] == needle[{pos[i], 3'b000} +: 8]);
      end
      hit = (pattern_size != 5'd0) && (&pos_ok);
   end

endmodule

>>> hw/rtl/line_filter_substring_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_filter_substring_match_unit
// Streaming line filter: drops control and escape bytes, echoes kept
// characters and reports per line whether a fixed needle occurred.
// ----------------------------------------------------------------------------
// Takes one byte transaction per cycle and gives at most one result per
// input: an echo of a kept character, or a line verdict on newline (and at
// end of input when the line is not empty). Each input is classified and
// matched in the cycle it is accepted; the output register captures the
// result as that cycle ends. req_tready stays high while the output register
// is empty or being drained, so throughput is one byte per clock as long as
// the consumer keeps up. The needle compare is a parallel window over the
// last NEEDLE_MAX-1 stored bytes. The csr channel is ready whenever reset is
// low; write it only while the stream is idle.
module line_filter_substring_match_unit
   import lfsm_pkg::*;
#(
   parameter int LINE_MAX   = 512,
   parameter int NEEDLE_MAX = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tuser,   // [0] kind
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_value, [8] line_matched,
                                    // [17:9] line_length, [23:18] zero
   output logic        rsp_tuser,   // [0] out_kind
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int LW         = $clog2(LINE_MAX);
   localparam int CW         = ((LW > 5) ? LW : 5) + 1;
   localparam int HIST_DEPTH = (NEEDLE_MAX > 1) ? NEEDLE_MAX - 1 : 1;

   // configuration registers
   logic [63:0] needle_low_ff, needle_high_ff;
   logic [4:0]  needle_len_ff;

   // line state
   logic [4:0]    skip_ff, skip_in;
   logic [LW-1:0] stored_ff, stored_in;
   logic          found_ff, found_in;
   char_type      hist_ff [HIST_DEPTH];
   char_type      hist_in [HIST_DEPTH];

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          emit;
   char_type      c;
   logic [4:0]    len_sat;
   logic          hit, enough;
   logic [LW+LEN_OUT_WIDTH-1:0] len_wide;

   assign csr_ready  = !reset;
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign c          = req_tdata;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign len_sat = (needle_len_ff > 5'(NEEDLE_MAX)) ? 5'(NEEDLE_MAX) : needle_len_ff;
   assign enough  = (CW'(stored_ff) + CW'(1)) >= CW'(len_sat);
   assign len_wide = {{LEN_OUT_WIDTH{1'b0}}, stored_ff};

   lfsm_match #(
      .NEEDLE_MAX (NEEDLE_MAX),
      .HIST_DEPTH (HIST_DEPTH)
   ) u_match (
      .char_value   (c),
      .history      (hist_ff),
      .needle       ({needle_high_ff, needle_low_ff}),
      .pattern_size (len_sat),
      .hit          (hit)
   );

   always_comb begin
      skip_in     = skip_ff;
      stored_in   = stored_ff;
      found_in    = found_ff;
      hist_in     = hist_ff;
      emit        = 1'b0;
      rsp_kind_in = OUT_ECHO;
      rsp_data_in = '0;

      if (req_accept) begin
         if (req_tuser == KIND_END) begin
            if (stored_ff != '0) begin
               emit        = 1'b1;
               rsp_kind_in = OUT_VERDICT;
               rsp_data_in = {6'd0, len_wide[LEN_OUT_WIDTH-1:0], found_ff, 8'd0};
            end
            skip_in   = '0;
            stored_in = '0;
            found_in  = 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) hist_in[i] = '0;
         end else if (skip_ff != '0) begin
            skip_in = skip_ff - 5'd1;
         end else if (c == BYTE_SKIP_SHORT) begin
            skip_in = SKIP_SHORT;
         end else if (c == BYTE_SKIP_LONG) begin
            skip_in = SKIP_LONG;
         end else if (c == BYTE_CR) begin
            skip_in = skip_ff;
         end else if (c == BYTE_LF) begin
            emit        = 1'b1;
            rsp_kind_in = OUT_VERDICT;
            rsp_data_in = {6'd0, len_wide[LEN_OUT_WIDTH-1:0], found_ff, 8'd0};
            stored_in   = '0;
            found_in    = 1'b0;
            for (int i = 0; i < HIST_DEPTH; i++) hist_in[i] = '0;
         end else if (((c < PRINT_LOW) || (c > PRINT_HIGH)) && (c != BYTE_TAB)) begin
            skip_in = skip_ff;
         end else if (stored_ff >= LW'(LINE_MAX - 1)) begin
            // line full: drop silently
            skip_in = skip_ff;
         end else begin
            emit        = 1'b1;
            rsp_kind_in = OUT_ECHO;
            rsp_data_in = {16'd0, c};
            stored_in   = stored_ff + LW'(1);
            found_in    = found_ff || (hit && enough);
            hist_in[0]  = c;
            for (int i = 1; i < HIST_DEPTH; i++) hist_in[i] = hist_ff[i-1];
         end
      end

      if (emit)              rsp_valid_in = 1'b1;
      else if (rsp_tready)   rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_low_ff  <= '0;
         needle_high_ff <= '0;
         needle_len_ff  <= '0;
         skip_ff        <= '0;
         stored_ff      <= '0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < HIST_DEPTH; i++) hist_ff[i] <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NEEDLE_LOW:  needle_low_ff  <= csr_data;
               REG_NEEDLE_HIGH: needle_high_ff <= csr_data;
               REG_NEEDLE_LEN:  needle_len_ff  <= csr_data[4:0];
               default: ;
            endcase
         end
         skip_ff      <= skip_in;
         stored_ff    <= stored_in;
         found_ff     <= found_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= LW'(LINE_MAX - 1))
      else $error("stored line length beyond LINE_MAX-1");

   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= SKIP_LONG)
      else $error("skip count out of range");

   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (stored_ff != '0))
      else $error("match flag set on empty line");

   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == OUT_ECHO) |-> (rsp_data_ff[23:8] == '0))
      else $error("echo carries verdict fields");

   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == KIND_DATA && skip_ff == '0 && c == BYTE_LF)
      |=> (stored_ff == '0 && !found_ff && rsp_valid_ff && rsp_kind_ff == OUT_VERDICT))
      else $error("newline did not close the line");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming line filter and needle match unit.
// Byte transactions are driven with random gaps and output stalls. A
// behavioral copy of the filter predicts every echo and line verdict, and
// each result transaction is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
   import lfsm_pkg::*;

   localparam int LINE_LIMIT = 512;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_value;
      logic       matched;
      logic [8:0] length;
   } line_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = KIND_DATA;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = REG_NEEDLE_LOW;
   logic [63:0] csr_data   = '0;

   // predicted filter state and needle registers
   logic [63:0] needle_lo_q    = '0;
   logic [63:0] needle_hi_q    = '0;
   logic [4:0]  needle_len_q   = '0;
   logic [4:0]  skip_left      = '0;
   int          open_line_size = 0;
   logic [7:0]  history [NEEDLE_BYTES] = '{default: 8'h00};
   logic        line_found     = 1'b0;

   line_result_type pending_results [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent    = 0;
   int echoes_seen   = 0;
   int verdicts_seen = 0;
   int matches_seen  = 0;
   int errors        = 0;

   line_filter_substring_match_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $error("timeout: %0d results still outstanding", pending_results.size());
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------------------
   // filter prediction
   // ------------------------------------------------------------------------
   function automatic logic [7:0] needle_char(input int i);
      return (i < 8) ? needle_lo_q[8*i +: 8] : needle_hi_q[8*(i-8) +: 8];
   endfunction

   function automatic int active_needle_len();
      return (needle_len_q > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len_q);
   endfunction

   function automatic void close_line();
      pending_results.push_back('{OUT_VERDICT, 8'h00, line_found, 9'(open_line_size)});
   endfunction

   function automatic void clear_line();
      open_line_size = 0;
      line_found     = 1'b0;
      for (int i = 0; i < NEEDLE_BYTES; i++) history[i] = 8'h00;
   endfunction

   function automatic void predict_item(input logic kind, input logic [7:0] c);
      int  n;
      logic hit;
      if (kind == KIND_END) begin
         if (open_line_size > 0) close_line();
         skip_left = '0;
         clear_line();
      end else if (skip_left != 0) begin
         skip_left = skip_left - 5'd1;
      end else if (c == BYTE_SKIP_SHORT) begin
         skip_left = SKIP_SHORT;
      end else if (c == BYTE_SKIP_LONG) begin
         skip_left = SKIP_LONG;
      end else if (c == BYTE_LF) begin
         close_line();
         clear_line();
      end else if ((c == BYTE_TAB || (c >= PRINT_LOW && c <= PRINT_HIGH))
                   && open_line_size < LINE_LIMIT - 1) begin
         n = active_needle_len();
         // window compare: incoming byte is the needle's last byte
         if (n > 0 && open_line_size + 1 >= n) begin
            hit = (c == needle_char(n - 1));
            for (int i = 1; i < n; i++) begin
               if (history[i-1] != needle_char(n - 1 - i)) hit = 1'b0;
            end
            if (hit) line_found = 1'b1;
         end
         for (int i = NEEDLE_BYTES - 1; i > 0; i--) history[i] = history[i-1];
         history[0] = c;
         open_line_size++;
         pending_results.push_back('{OUT_ECHO, c, 1'b0, 9'd0});
      end
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input logic kind, input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_item(kind, value);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(KIND_DATA, text[i]);
   endtask

   // stop the stream and let every predicted result come out
   task automatic drain_stream();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         REG_NEEDLE_LOW:  needle_lo_q  = value;
         REG_NEEDLE_HIGH: needle_hi_q  = value;
         REG_NEEDLE_LEN:  needle_len_q = value[4:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [127:0] text_bytes(input string text);
      logic [127:0] bytes;
      bytes = '0;
      for (int i = 0; i < text.len() && i < NEEDLE_BYTES; i++) bytes[8*i +: 8] = text[i];
      return bytes;
   endfunction

   function automatic logic [127:0] random_needle(input string alphabet);
      logic [127:0] bytes;
      for (int i = 0; i < NEEDLE_BYTES; i++)
         bytes[8*i +: 8] = alphabet[$urandom_range(alphabet.len() - 1)];
      return bytes;
   endfunction

   task automatic set_needle(input logic [127:0] bytes, input logic [4:0] len);
      drain_stream();
      write_reg(REG_NEEDLE_LOW,  bytes[63:0]);
      write_reg(REG_NEEDLE_HIGH, bytes[127:64]);
      write_reg(REG_NEEDLE_LEN,  {59'd0, len});
   endtask

   // one line of mostly printable text, seeded with needle fragments
   task automatic send_random_line(input int max_len);
      int count;
      int pick;
      int n;
      n = active_needle_len();
      count = $urandom_range(max_len);
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 10 && n > 0) begin
            for (int j = 0; j < n; j++) send_item(KIND_DATA, needle_char(j));
         end else if (pick < 20) begin
            send_item(KIND_DATA, 8'($urandom_range(255)));
         end else if (pick < 55 && n > 0) begin
            send_item(KIND_DATA, needle_char($urandom_range(n - 1)));
         end else begin
            send_item(KIND_DATA, 8'($urandom_range(PRINT_HIGH, PRINT_LOW)));
         end
      end
      if ($urandom_range(9) == 0) send_item(KIND_END, 8'($urandom_range(255)));
      else send_item(KIND_DATA, BYTE_LF);
   endtask

   // ------------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      line_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("out_kind mismatch: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== want.char_value) begin
               $error("char_value mismatch: expected %h, got %h",
                      want.char_value, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[8] !== want.matched) begin
               $error("line_matched mismatch: expected %0d, got %0d",
                      want.matched, rsp_tdata[8]);
               errors++;
            end
            if (rsp_tdata[17:9] !== want.length) begin
               $error("line_length mismatch: expected %0d, got %0d",
                      want.length, rsp_tdata[17:9]);
               errors++;
            end
            if (rsp_tdata[23:18] !== 6'd0) begin
               $error("tdata padding mismatch: expected 0, got %h", rsp_tdata[23:18]);
               errors++;
            end
            if (want.kind == OUT_VERDICT) begin
               verdicts_seen++;
               if (want.matched) matches_seen++;
            end else begin
               echoes_seen++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_filtering();
      set_needle(text_bytes("ab"), 5'd2);
      send_text("xab");
      send_item(KIND_DATA, BYTE_CR);
      send_item(KIND_DATA, BYTE_TAB);
      send_item(KIND_DATA, 8'h00);
      send_item(KIND_DATA, 8'h1F);
      send_item(KIND_DATA, PRINT_LOW);
      send_item(KIND_DATA, PRINT_HIGH);
      send_item(KIND_DATA, 8'h7F);
      send_item(KIND_DATA, 8'h80);
      send_item(KIND_DATA, BYTE_LF);
      send_item(KIND_DATA, BYTE_LF);          // empty line still gets a verdict
      // markers inside a skip window are skipped too
      send_item(KIND_DATA, BYTE_SKIP_SHORT);
      send_item(KIND_DATA, BYTE_LF);
      send_item(KIND_DATA, BYTE_SKIP_LONG);
      send_item(KIND_DATA, "q");
      send_item(KIND_DATA, "c");
      send_item(KIND_DATA, BYTE_SKIP_LONG);
      for (int i = 0; i < 16; i++)
         send_item(KIND_DATA, (i % 3 == 0) ? BYTE_LF :
                              (i % 3 == 1) ? BYTE_SKIP_SHORT : 8'h61);
      send_item(KIND_DATA, "d");
      send_item(KIND_END, 8'h00);             // flushes the open line
      send_item(KIND_END, 8'hFF);             // empty: nothing comes out
      send_item(KIND_DATA, BYTE_SKIP_SHORT);
      send_item(KIND_END, 8'h5A);             // end of input cancels the skip
      send_item(KIND_DATA, "e");
      send_item(KIND_DATA, BYTE_LF);
   endtask

   task automatic test_needle_registers();
      // all-ones pattern, length saturates; stored bytes are never 0xFF
      set_needle('1, 5'd31);
      send_text("ab~");
      send_item(KIND_DATA, BYTE_LF);
      set_needle(text_bytes("0123456789ABCDEF"), 5'd16);
      send_text("x0123456789ABCDEF");
      send_item(KIND_DATA, BYTE_LF);
      set_needle(text_bytes("a") | (128'h62 << 16), 5'd3);   // zero byte in the middle
      send_text("a b");
      send_item(KIND_DATA, BYTE_LF);
      set_needle(text_bytes("a"), 5'd0);
      send_text("aa");
      send_item(KIND_DATA, BYTE_LF);
      set_needle(text_bytes("a"), 5'd1);
      send_text("za");
      send_item(KIND_DATA, BYTE_LF);
      // needle rewritten mid-line: earlier match holds, history carries over
      set_needle(text_bytes("ab"), 5'd2);
      send_text("ab");
      set_needle(text_bytes("zq"), 5'd2);
      send_text("x");
      send_item(KIND_DATA, BYTE_LF);
      send_text("a");
      set_needle(text_bytes("ab"), 5'd2);
      send_text("b");
      send_item(KIND_DATA, BYTE_LF);
   endtask

   task automatic test_long_line();
      set_needle(text_bytes("yz"), 5'd2);
      for (int i = 0; i < LINE_LIMIT - 2; i++) send_item(KIND_DATA, "a");
      send_text("yzz");                      // only the 'y' still fits
      send_item(KIND_DATA, BYTE_LF);
      send_text("yz");
      send_item(KIND_DATA, BYTE_LF);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int target, input logic [127:0] needle,
                                      input logic [4:0] len);
      int start;
      set_needle(needle, len);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      start = items_sent;
      while (items_sent - start < target) send_random_line(40);
   endtask

   initial begin
      send_idle_pct = 15;
      recv_idle_pct = 81;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_filtering();
      test_needle_registers();
      test_long_line();
      test_random_traffic(15, 81, 230, random_needle("abc"), 5'd3);
      test_random_traffic(81, 15, 230, random_needle("ab"), 5'd31);
      test_random_traffic(0, 0, 240, random_needle("abcdefgh~ "), 5'd1);

      drain_stream();
      repeat (10) @(posedge clock);
      $display("Sent %0d input transactions: %0d echoes, %0d line verdicts, %0d with a match,",
               items_sent, echoes_seen, verdicts_seen, matches_seen);
      $display("across skip markers, control bytes, long lines and needle lengths 0 to 31.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
